// File: rtl/utf8_stream_decoder_unit_assert.svh
// Assertion macros shared by the UTF-8 stream decoder modules
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define U8SD_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("u8sd assertion failed");

// next-cycle implication, disabled while in reset
`define U8SD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("u8sd assertion failed");

`endif

// File: rtl/u8sd_pkg.sv
// Types, status codes and constants of the UTF-8 stream decoder
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned ACC_W = 31;
    localparam int unsigned CNT_W = 3;

    localparam logic [ACC_W-1:0] CP_MAX = ACC_W'(32'h0010_FFFF);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STRAY    = 3'd1,
        ST_BADLEAD  = 3'd2,
        ST_BADCONT  = 3'd3,
        ST_OVERLONG = 3'd4,
        ST_RANGE    = 3'd5
    } status_t;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        status_t         status;
    } result_t;

    // smallest legal value for a given continuation count
    function automatic logic [ACC_W-1:0] min_for_len(input logic [CNT_W-1:0] len);
        logic [ACC_W-1:0] mn;
        case (len)
            3'd1:    mn = ACC_W'(32'h0000_0080);
            3'd2:    mn = ACC_W'(32'h0000_0800);
            3'd3:    mn = ACC_W'(32'h0001_0000);
            3'd4:    mn = ACC_W'(32'h0020_0000);
            3'd5:    mn = ACC_W'(32'h0400_0000);
            default: mn = '0;
        endcase
        return mn;
    endfunction

endpackage

`default_nettype wire

// File: rtl/u8sd_decode.sv
// Sequence state and per-byte decode of the UTF-8 stream decoder
`default_nettype none

module u8sd_decode (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_byte,
    output u8sd_pkg::result_t      res
);
    import u8sd_pkg::*;

    logic [CNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [CNT_W-1:0] seq_length_reg, seq_length_next;
    logic [ACC_W-1:0] accumulator_reg, accumulator_next;
    logic [ACC_W-1:0] acc_shift;

    assign acc_shift = {accumulator_reg[ACC_W-7:0], in_byte[5:0]};

    always_comb begin
        bytes_left_next  = bytes_left_reg;
        seq_length_next  = seq_length_reg;
        accumulator_next = accumulator_reg;
        res.valid        = 1'b0;
        res.code_point   = '0;
        res.status       = ST_OK;
        if (in_valid) begin
            if (bytes_left_reg == '0) begin
                if (!in_byte[7]) begin
                    res.valid      = 1'b1;
                    res.code_point = CP_W'(in_byte);
                end else if (!in_byte[6]) begin
                    res.valid  = 1'b1;
                    res.status = ST_STRAY;
                end else if (in_byte[7:1] == 7'b111_1111) begin
                    res.valid  = 1'b1;
                    res.status = ST_BADLEAD;
                end else if (!in_byte[5]) begin
                    bytes_left_next  = 3'd1;
                    accumulator_next = ACC_W'(in_byte[4:0]);
                end else if (!in_byte[4]) begin
                    bytes_left_next  = 3'd2;
                    accumulator_next = ACC_W'(in_byte[3:0]);
                end else if (!in_byte[3]) begin
                    bytes_left_next  = 3'd3;
                    accumulator_next = ACC_W'(in_byte[2:0]);
                end else if (!in_byte[2]) begin
                    bytes_left_next  = 3'd4;
                    accumulator_next = ACC_W'(in_byte[1:0]);
                end else begin
                    bytes_left_next  = 3'd5;
                    accumulator_next = ACC_W'(in_byte[0]);
                end
                seq_length_next = bytes_left_next;
            end else if (in_byte[7:6] != 2'b10) begin
                bytes_left_next  = '0;
                seq_length_next  = '0;
                accumulator_next = '0;
                res.valid        = 1'b1;
                res.status       = ST_BADCONT;
            end else if (bytes_left_reg == 3'd1) begin
                bytes_left_next  = '0;
                seq_length_next  = '0;
                accumulator_next = '0;
                res.valid        = 1'b1;
                if (acc_shift < min_for_len(seq_length_reg)) begin
                    res.status = ST_OVERLONG;
                end else if (acc_shift > CP_MAX) begin
                    res.status = ST_RANGE;
                end else begin
                    res.code_point = acc_shift[CP_W-1:0];
                end
            end else begin
                bytes_left_next  = bytes_left_reg - 3'd1;
                accumulator_next = acc_shift;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg  <= '0;
            seq_length_reg  <= '0;
            accumulator_reg <= '0;
        end else begin
            bytes_left_reg  <= bytes_left_next;
            seq_length_reg  <= seq_length_next;
            accumulator_reg <= accumulator_next;
        end
    end

`include "utf8_stream_decoder_unit_assert.svh"

    `U8SD_ASSERT_IMPLIES(a_left_within_len, aclk, aresetn, 1'b1, bytes_left_reg <= seq_length_reg)
    `U8SD_ASSERT_IMPLIES(a_len_in_range, aclk, aresetn, bytes_left_reg != '0, (seq_length_reg >= 3'd1) && (seq_length_reg <= 3'd5))
    `U8SD_ASSERT_NEXT(a_final_goes_idle, aclk, aresetn, in_valid && res.valid, bytes_left_reg == '0)

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder: one byte in, zero or one code point out per transaction.
// Results are registered in the output register, or in the skid entry while the output register is held.
// Throughput: one byte per cycle while the skid entry is empty; the output register plus one skid entry
// keep s_tready high while one result waits on m_tready.
// Reset: aresetn (synchronous, active low) returns the decoder to idle and
// empties the output register and skid entry.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata    // [20:0] code_point, [23:21] status
);
    import u8sd_pkg::*;

    result_t res;
    logic    accept;
    logic    out_take;

    logic               out_valid_reg;
    logic [CP_W-1:0]    out_cp_reg;
    status_t            out_status_reg;
    logic               skid_valid_reg;
    logic [CP_W-1:0]    skid_cp_reg;
    status_t            skid_status_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    u8sd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_byte  (s_tdata),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_take) begin
            out_valid_reg <= res.valid;
        end else if (res.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_cp_reg     <= skid_cp_reg;
                out_status_reg <= skid_status_reg;
            end
        end else if (!out_valid_reg || out_take) begin
            out_cp_reg     <= res.code_point;
            out_status_reg <= res.status;
        end else if (res.valid) begin
            skid_cp_reg     <= res.code_point;
            skid_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_cp_reg};

`include "utf8_stream_decoder_unit_assert.svh"

    `U8SD_ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `U8SD_ASSERT_IMPLIES(a_error_zero_cp, aclk, aresetn, out_valid_reg && (out_status_reg != ST_OK), out_cp_reg == '0)
    `U8SD_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, accept && res.valid && out_valid_reg && !m_tready, skid_valid_reg)
    `U8SD_ASSERT_IMPLIES(a_cp_in_range, aclk, aresetn, out_valid_reg, ACC_W'(out_cp_reg) <= CP_MAX)

endmodule

`default_nettype wire
